/* rtl/go_to_pose_controller_macros.svh */
// Assertion macros used by the go-to-pose controller checker.
`ifndef GO_TO_POSE_CONTROLLER_MACROS_SVH
`define GO_TO_POSE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, inactive while rst_n is low.
`define GTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, inactive while rst_n is low.
`define GTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gtp_pkg.sv */
// Package with the types, constants and helper functions of the go-to-pose controller.
`default_nettype none
package gtp_pkg;

  localparam int POS_W        = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CW           = POS_W + 4;
  localparam int ZW           = 25;
  localparam int AW           = 19;
  localparam int CFG_IDX_W    = 4;

  localparam int IN_TDATA_W   = ((2 * POS_W + 16 + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_TUSER_W  = 3;

  localparam logic signed [AW-1:0] ANG_PI     = AW'(25736);
  localparam logic signed [AW-1:0] ANG_TWO_PI = AW'(51472);
  localparam logic signed [AW+1:0] ANG_ONE    = (AW+2)'(8192);
  localparam logic signed [ZW-1:0] FRAC_PI    = ZW'(3294199);
  localparam logic signed [ZW-1:0] Z_ROUND    = ZW'(64);

  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_YAW   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_POS_TOL    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_YAW_TOL    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_GATE  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_FWD_SPEED  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_FB_PERIOD  = CFG_IDX_W'(7);

  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_SUCCEEDED = 2'd1;
  localparam logic [1:0] ST_CANCELED  = 2'd2;
  localparam logic [1:0] ST_IDLE      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SUM,
    S_ITER,
    S_DECIDE
  } gtp_state_t;

  typedef struct packed {
    logic              load;
    logic              prep;
    logic              sum;
    logic              iter;
    logic              commit;
    logic [STEP_W-1:0] step;
  } gtp_cmd_t;

  // Arctangent of 2^-i, 20 fraction bits.
  function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [4:0] i;
    logic signed [ZW-1:0] v;
    i = 5'(idx);
    case (i)
      5'd0:  v = ZW'(823550);
      5'd1:  v = ZW'(486170);
      5'd2:  v = ZW'(256879);
      5'd3:  v = ZW'(130396);
      5'd4:  v = ZW'(65451);
      5'd5:  v = ZW'(32757);
      5'd6:  v = ZW'(16383);
      5'd7:  v = ZW'(8192);
      5'd8:  v = ZW'(4096);
      5'd9:  v = ZW'(2048);
      5'd10: v = ZW'(1024);
      5'd11: v = ZW'(512);
      5'd12: v = ZW'(256);
      5'd13: v = ZW'(128);
      5'd14: v = ZW'(64);
      5'd15: v = ZW'(32);
      5'd16: v = ZW'(16);
      5'd17: v = ZW'(8);
      5'd18: v = ZW'(4);
      5'd19: v = ZW'(2);
      5'd20: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Two steps of 2*pi each way cover every difference that can arise here.
  function automatic logic signed [AW-1:0] wrap_angle(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    r = a;
    if (r > ANG_PI) r = r - ANG_TWO_PI;
    if (r > ANG_PI) r = r - ANG_TWO_PI;
    if (r < -ANG_PI) r = r + ANG_TWO_PI;
    if (r < -ANG_PI) r = r + ANG_TWO_PI;
    return r;
  endfunction

  function automatic logic [AW-1:0] abs_angle(input logic signed [AW-1:0] a);
    return a[AW-1] ? AW'(-a) : AW'(a);
  endfunction

  // Gain of two, clamped to plus or minus one.
  function automatic logic signed [14:0] turn_rate(input logic signed [AW-1:0] e);
    logic signed [AW+1:0] r;
    r = {e[AW-1], e, 1'b0};
    if (r > ANG_ONE) r = ANG_ONE;
    if (r < -ANG_ONE) r = -ANG_ONE;
    return r[14:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/gtp_ctrl.sv */
// Sequencer of the go-to-pose controller: handshakes, phases and CORDIC step count.
`default_nettype none
module gtp_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output gtp_pkg::gtp_cmd_t   cmd
);
  import gtp_pkg::*;

  gtp_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_PREP;
      S_PREP:   state_nxt = S_SUM;
      S_SUM:    state_nxt = S_ITER;
      S_ITER:   if (step_r == LAST_STEP) state_nxt = S_DECIDE;
      S_DECIDE: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.step   = step_r;
    in_tready  = 1'b0;
    step_nxt   = step_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_PREP: cmd.prep = 1'b1;
      S_SUM: begin
        cmd.sum  = 1'b1;
        step_nxt = '0;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        step_nxt = step_r + 1'b1;
      end
      S_DECIDE: cmd.commit = out_free;
      default: ;
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/gtp_dp.sv */
// Datapath of the go-to-pose controller: registers, distance test, CORDIC and decision.
`default_nettype none
module gtp_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  gtp_pkg::gtp_cmd_t                cmd,
  input  wire [gtp_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire                              in_tuser,
  output logic [gtp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [gtp_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  wire                              cfg_valid,
  input  wire [gtp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [gtp_pkg::POS_W-1:0]         cfg_data
);
  import gtp_pkg::*;

  // Configuration and persistent state.
  logic signed [POS_W-1:0] goal_x_r, goal_y_r;
  logic signed [15:0]      goal_yaw_r;
  logic [15:0]             pos_tol_r;
  logic [14:0]             yaw_tol_r, head_gate_r;
  logic [13:0]             fwd_speed_r;
  logic [7:0]              fb_period_r;
  logic [7:0]              tick_r, tick_nxt;
  logic                    finished_r, finished_nxt;

  // Per-tick working registers.
  logic signed [15:0]      pyaw_r;
  logic                    cancel_r;
  logic signed [POS_W:0]   dx_r, dy_r;
  logic                    big_r, far_r;
  logic [31:0]             sqx_r, sqy_r, tolsq_r;
  logic signed [CW-1:0]    x_r, y_r;
  logic signed [ZW-1:0]    z_r;

  // Result registers.
  logic [13:0]             lin_r, lin_nxt;
  logic signed [14:0]      ang_r, ang_nxt;
  logic [1:0]              status_r, status_nxt;
  logic                    fb_r, fb_nxt;

  logic signed [POS_W-1:0] px, py;
  logic [POS_W:0]          adx, ady;
  logic signed [CW-1:0]    xe, ye, xs, ys;
  logic signed [ZW-1:0]    zr;
  logic signed [AW-1:0]    herr, yerr;
  logic [7:0]              tick_inc;
  logic                    cfg_hit;

  assign px = in_tdata[POS_W-1:0];
  assign py = in_tdata[2*POS_W-1:POS_W];

  assign adx = dx_r[POS_W] ? (POS_W+1)'(-dx_r) : (POS_W+1)'(dx_r);
  assign ady = dy_r[POS_W] ? (POS_W+1)'(-dy_r) : (POS_W+1)'(dy_r);

  assign xe = CW'(dx_r);
  assign ye = CW'(dy_r);
  assign xs = x_r >>> cmd.step;
  assign ys = y_r >>> cmd.step;

  assign zr   = (z_r + Z_ROUND) >>> 7;
  assign herr = wrap_angle(AW'(zr[AW-1:0]) - AW'(pyaw_r));
  assign yerr = wrap_angle(AW'(goal_yaw_r) - AW'(pyaw_r));

  assign tick_inc = tick_r + 8'd1;
  assign cfg_hit  = cfg_valid && (cfg_index <= REG_FB_PERIOD);

  always_comb begin
    lin_nxt      = '0;
    ang_nxt      = '0;
    status_nxt   = ST_RUNNING;
    fb_nxt       = 1'b0;
    tick_nxt     = tick_r;
    finished_nxt = finished_r;
    if (finished_r) begin
      status_nxt = ST_IDLE;
    end else if (cancel_r) begin
      finished_nxt = 1'b1;
      status_nxt   = ST_CANCELED;
    end else begin
      tick_nxt = tick_inc;
      if (tick_inc >= fb_period_r) begin
        fb_nxt   = 1'b1;
        tick_nxt = '0;
      end
      if (far_r) begin
        ang_nxt = turn_rate(herr);
        if (abs_angle(herr) < AW'(head_gate_r)) lin_nxt = fwd_speed_r;
      end else if (abs_angle(yerr) > AW'(yaw_tol_r)) begin
        ang_nxt = turn_rate(yerr);
      end else begin
        finished_nxt = 1'b1;
        status_nxt   = ST_SUCCEEDED;
      end
    end
  end

  // Configuration, tick counter and finished flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      goal_yaw_r  <= '0;
      pos_tol_r   <= 16'd4915;
      yaw_tol_r   <= 15'd1430;
      head_gate_r <= 15'd1638;
      fwd_speed_r <= 14'd1638;
      fb_period_r <= 8'd10;
      tick_r      <= '0;
      finished_r  <= 1'b0;
    end else if (cfg_hit) begin
      case (cfg_index)
        REG_GOAL_X:    goal_x_r    <= cfg_data;
        REG_GOAL_Y:    goal_y_r    <= cfg_data;
        REG_GOAL_YAW:  goal_yaw_r  <= cfg_data[15:0];
        REG_POS_TOL:   pos_tol_r   <= cfg_data[15:0];
        REG_YAW_TOL:   yaw_tol_r   <= cfg_data[14:0];
        REG_HEAD_GATE: head_gate_r <= cfg_data[14:0];
        REG_FWD_SPEED: fwd_speed_r <= cfg_data[13:0];
        REG_FB_PERIOD: fb_period_r <= cfg_data[7:0];
        default: ;
      endcase
      tick_r     <= '0;
      finished_r <= 1'b0;
    end else if (cmd.commit) begin
      tick_r     <= tick_nxt;
      finished_r <= finished_nxt;
    end
  end

  // Working registers and results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pyaw_r   <= in_tdata[2*POS_W+15:2*POS_W];
      cancel_r <= in_tuser;
      dx_r     <= (POS_W+1)'(goal_x_r) - (POS_W+1)'(px);
      dy_r     <= (POS_W+1)'(goal_y_r) - (POS_W+1)'(py);
    end
    if (cmd.prep) begin
      big_r   <= (adx > (POS_W+1)'(pos_tol_r)) || (ady > (POS_W+1)'(pos_tol_r));
      sqx_r   <= adx[15:0] * adx[15:0];
      sqy_r   <= ady[15:0] * ady[15:0];
      tolsq_r <= pos_tol_r * pos_tol_r;
      if (dx_r < 0) begin
        x_r <= -xe;
        y_r <= -ye;
        z_r <= (dy_r >= 0) ? FRAC_PI : -FRAC_PI;
      end else begin
        x_r <= xe;
        y_r <= ye;
        z_r <= '0;
      end
    end
    if (cmd.sum) begin
      far_r <= big_r || ((33'(sqx_r) + 33'(sqy_r)) > 33'(tolsq_r));
    end
    if (cmd.iter) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_lut(cmd.step);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_lut(cmd.step);
      end
    end
    if (cmd.commit) begin
      lin_r    <= lin_nxt;
      ang_r    <= ang_nxt;
      status_r <= status_nxt;
      fb_r     <= fb_nxt;
    end
  end

  assign out_tdata = {3'b000, ang_r, lin_r};
  assign out_tuser = {fb_r, status_r};

endmodule
`default_nettype wire

/* rtl/go_to_pose_controller.sv */
// Top level of the go-to-pose controller: sequencer plus datapath.
// A taken request passes through the prepare, sum, CORDIC iteration and decision phases.
// A new request is taken only after the decision phase of the last one, as the CORDIC is iterative.
// A result waiting at the output holds the block in its decision phase until taken.
// Reset (rst_n low at a clock edge, synchronous) restores the default configuration,
// clears the tick counter and finished flag, and empties the output register.
`default_nettype none
module go_to_pose_controller (
  input  wire                              clk,
  input  wire                              rst_n,
  // Pose request: tdata = pose_x [31:0], pose_y [63:32], pose_yaw [79:64].
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [gtp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser = cancel_request.
  input  wire                              in_tuser,
  // Command: tdata = linear_velocity [13:0], angular_velocity [28:14], zero padding.
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [gtp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser = goal_status [1:0], feedback_due [2].
  output logic [gtp_pkg::OUT_TUSER_W-1:0]  out_tuser,
  // Register writes; indexes beyond the list are ignored.
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [gtp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [gtp_pkg::POS_W-1:0]         cfg_data
);
  import gtp_pkg::*;

  gtp_cmd_t cmd;

  // Writes must arrive only between ticks; the block does not enforce this, and the port always takes them.
  assign cfg_ready = 1'b1;

  gtp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gtp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

/* rtl/gtp_checker.sv */
// Port-level checker of the go-to-pose controller, bound to the top level.
`default_nettype none
`include "go_to_pose_controller_macros.svh"
module gtp_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [gtp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire [gtp_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import gtp_pkg::*;

  logic signed [14:0] ang;
  logic               done;

  assign ang  = out_tdata[28:14];
  assign done = (out_tuser[1:0] == ST_CANCELED) || (out_tuser[1:0] == ST_IDLE);

  `GTP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `GTP_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready, "request taken while busy")
  `GTP_ASSERT_IMP(a_done_quiet, out_tvalid && done, out_tdata[28:0] == '0 && !out_tuser[2], "motion after finish")
  `GTP_ASSERT_IMP(a_ang_clamp, out_tvalid, ang <= 15'sd8192 && ang >= -15'sd8192, "turn rate out of range")

endmodule

bind go_to_pose_controller gtp_checker u_gtp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the go-to-pose controller: stimulus, prediction and checking.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import gtp_pkg::*;

  // Register index that the block does not decode; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  // One pose request as the sender sees it.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        yaw;
    logic               cancel;
  } pose_req_t;

  // One velocity command with its status flags.
  typedef struct packed {
    logic [13:0] lin;
    logic [14:0] ang;
    logic [1:0]  status;
    logic        fb;
  } command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [POS_W-1:0]       cfg_data = '0;

  go_to_pose_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the controller's registers and state.
  logic signed [31:0] goal_x_sh, goal_y_sh;
  logic signed [15:0] goal_yaw_sh;
  logic [15:0]        pos_tol_sh;
  logic [14:0]        yaw_tol_sh, gate_sh;
  logic [13:0]        speed_sh;
  logic [7:0]         period_sh, ticks_sh;
  logic               done_sh;

  pose_req_t pose_q[$];      // requests waiting for the driver
  command_t  command_q[$];   // commands the block still owes us
  pose_req_t pose_cur;
  int        errors = 0;
  int        poses_taken = 0;

  // Arctangent of 2^-i with 20 fraction bits.
  longint atan_steps[16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                             4096, 2048, 1024, 512, 256, 128, 64, 32};

  function automatic int heading_to(input longint ry, input longint rx);
    longint px, py, acc, sx, sy;
    px = rx;
    py = ry;
    acc = 0;
    // Goals behind the robot start from a half turn and mirror the vector.
    if (px < 0) begin
      acc = (py >= 0) ? 3294199 : -3294199;
      px = -px;
      py = -py;
    end
    for (int i = 0; i < 16; i++) begin
      sx = px >>> i;
      sy = py >>> i;
      if (py > 0) begin
        px += sy; py -= sx; acc += atan_steps[i];
      end else begin
        px -= sy; py += sx; acc -= atan_steps[i];
      end
    end
    return int'((acc + 64) >>> 7);
  endfunction

  function automatic int fold_angle(input int a);
    int r;
    r = a;
    while (r > 25736) r -= 51472;
    while (r < -25736) r += 51472;
    return r;
  endfunction

  function automatic int steer(input int err);
    int r;
    r = 2 * err;
    if (r > 8192) r = 8192;
    if (r < -8192) r = -8192;
    return r;
  endfunction

  // Works out the command one accepted pose request must produce.
  task automatic predict_command(input pose_req_t p);
    command_t c;
    longint dx, dy, tol;
    int err, turn;
    logic far;
    c = '0;
    turn = 0;
    if (done_sh) begin
      c.status = ST_IDLE;
    end else if (p.cancel) begin
      done_sh = 1'b1;
      c.status = ST_CANCELED;
    end else begin
      c.status = ST_RUNNING;
      ticks_sh = ticks_sh + 8'd1;
      if (ticks_sh >= period_sh) begin
        c.fb = 1'b1;
        ticks_sh = '0;
      end
      dx = longint'(goal_x_sh) - longint'(p.x);
      dy = longint'(goal_y_sh) - longint'(p.y);
      tol = longint'(pos_tol_sh);
      if (dx > tol || -dx > tol || dy > tol || -dy > tol) far = 1'b1;
      else far = (dx * dx + dy * dy) > tol * tol;
      if (far) begin
        err = fold_angle(heading_to(dy, dx) - int'($signed(p.yaw)));
        turn = steer(err);
        if ((err < 0 ? -err : err) < int'(gate_sh)) c.lin = speed_sh;
      end else begin
        err = fold_angle(int'(goal_yaw_sh) - int'($signed(p.yaw)));
        if ((err < 0 ? -err : err) > int'(yaw_tol_sh)) begin
          turn = steer(err);
        end else begin
          done_sh = 1'b1;
          c.status = ST_SUCCEEDED;
        end
      end
    end
    c.ang = turn[14:0];
    command_q.push_back(c);
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_GOAL_X:    goal_x_sh = val;
      REG_GOAL_Y:    goal_y_sh = val;
      REG_GOAL_YAW:  goal_yaw_sh = val[15:0];
      REG_POS_TOL:   pos_tol_sh = val[15:0];
      REG_YAW_TOL:   yaw_tol_sh = val[14:0];
      REG_HEAD_GATE: gate_sh = val[14:0];
      REG_FWD_SPEED: speed_sh = val[13:0];
      REG_FB_PERIOD: period_sh = val[7:0];
      default:       return;
    endcase
    // Any write to a real register re-arms the goal.
    done_sh = 1'b0;
    ticks_sh = '0;
  endtask

  // Called just after a rising edge; leaves cfg_valid high for a following write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
  endtask

  // Waits until every request went in and every command came back, then lets the
  // pipeline settle before the next register write.
  task automatic drain;
    do @(posedge clk); while (pose_q.size() != 0 || in_tvalid || command_q.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic queue_pose(input int x, input int y, input int yaw, input logic cancel);
    pose_req_t p;
    p.x = x;
    p.y = y;
    p.yaw = yaw[15:0];
    p.cancel = cancel;
    pose_q.push_back(p);
  endtask

  function automatic int spread(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // Random pose: close to the goal in almost half the cases so that arrival and the final turn are reached.
  task automatic queue_random_pose;
    int kind, x, y, yaw, tol;
    kind = $urandom_range(0, 99);
    tol = int'(pos_tol_sh);
    if (kind < 45) begin
      x = goal_x_sh + spread(2 * tol + 1);
      y = goal_y_sh + spread(2 * tol + 1);
    end else if (kind < 80) begin
      x = goal_x_sh + spread(1 << 20);
      y = goal_y_sh + spread(1 << 20);
    end else if (kind < 95) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      y = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    kind = $urandom_range(0, 9);
    if (kind == 0) yaw = $urandom;
    else if (kind < 5) yaw = int'(goal_yaw_sh) + spread(int'(yaw_tol_sh) + 300);
    else yaw = spread(25736);
    queue_pose(x, y, yaw, $urandom_range(0, 39) == 0);
  endtask

  // Random value for a register; one time in five it is one of its extremes.
  function automatic logic [31:0] register_value(input logic [CFG_IDX_W-1:0] idx);
    logic edge_pick, hi;
    edge_pick = $urandom_range(0, 4) == 0;
    hi = $urandom_range(0, 1);
    case (idx)
      REG_GOAL_X, REG_GOAL_Y:
        return edge_pick ? (hi ? 32'h7FFF_FFFF : 32'h8000_0000) :
               ($urandom_range(0, 3) == 0 ? $urandom : 32'(spread(1 << 22)));
      REG_GOAL_YAW:
        return edge_pick ? (hi ? 32'd25736 : 32'(-25736)) :
               ($urandom_range(0, 9) == 0 ? $urandom : 32'(spread(25736)));
      REG_POS_TOL:   return edge_pick ? (hi ? 32'd65535 : 32'd0) : $urandom_range(0, 65535);
      REG_YAW_TOL, REG_HEAD_GATE:
        return edge_pick ? (hi ? 32'd25736 : 32'd0) : $urandom_range(0, 25736);
      REG_FWD_SPEED: return edge_pick ? (hi ? 32'd8192 : 32'd0) : $urandom_range(0, 8192);
      REG_FB_PERIOD: return edge_pick ? (hi ? 32'd255 : 32'd1) : $urandom_range(1, 30);
      default:       return $urandom;
    endcase
  endfunction

  // Sender: bursts of random length with random gaps, fed from pose_q.
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_command(pose_cur);
        poses_taken <= poses_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pose_q.size() != 0) begin
          pose_cur = pose_q.pop_front();
          in_tdata <= {pose_cur.yaw, pose_cur.y, pose_cur.x};
          in_tuser <= pose_cur.cancel;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            // A quarter of the bursts follow on with no gap at all.
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern that moves through its modes in turn, plus one long hold-off
  // once a few hundred requests went in, so the output backs up into the input.
  int    rx_cycle = 0;
  int    hold_left = 0;
  logic  hold_done = 1'b0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!hold_done && poses_taken >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_cycle[11:10])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= $urandom_range(0, 1);
        2'd2: out_tready <= $urandom_range(0, 3) == 0;
        default: out_tready <= rx_cycle[3:0] != 4'd0;
      endcase
    end
  end

  // Monitor: every command is checked field by field against the oldest prediction.
  always @(posedge clk) begin
    command_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.lin = out_tdata[13:0];
      got.ang = out_tdata[28:14];
      got.status = out_tuser[1:0];
      got.fb = out_tuser[2];
      if (command_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= MAX_REPORTS)
          $display("unexpected command: lin %0d ang %0d status %0d fb %0d",
                   got.lin, $signed(got.ang), got.status, got.fb);
      end else begin
        want = command_q.pop_front();
        if (got != want) begin
          errors = errors + 1;
          if (errors <= MAX_REPORTS)
            $display("command mismatch: expected lin %0d ang %0d status %0d fb %0d, got %0d %0d %0d %0d",
                     want.lin, $signed(want.ang), want.status, want.fb,
                     got.lin, $signed(got.ang), got.status, got.fb);
        end
      end
    end
  end

  // Watchdog: too long without any handshake on any channel ends the run.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [CFG_IDX_W-1:0] idx;
    goal_x_sh = '0;
    goal_y_sh = '0;
    goal_yaw_sh = '0;
    pos_tol_sh = 16'd4915;
    yaw_tol_sh = 15'd1430;
    gate_sh = 15'd1638;
    speed_sh = 14'd1638;
    period_sh = 8'd10;
    ticks_sh = '0;
    done_sh = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults: arrival right at the origin, then a cancel that must be ignored.
    queue_pose(0, 0, 0, 1'b0);
    queue_pose(0, 0, 0, 1'b1);
    drain();

    // Feedback every tick; the extremes of the pose fields, goals straight behind,
    // left and right, a turn in place at the goal, then arrival, after which a cancel meets the idle state.
    write_register(REG_FB_PERIOD, 32'd1);
    cfg_valid <= 1'b0;
    queue_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF, 1'b0);
    queue_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000, 1'b0);
    queue_pose(100000, 0, 0, 1'b0);
    queue_pose(100000, -5, 25736, 1'b0);
    queue_pose(0, 100000, -25736, 1'b0);
    queue_pose(0, -100000, 0, 1'b0);
    queue_pose(-100000, 0, 800, 1'b0);
    queue_pose(10, 10, 20000, 1'b0);
    queue_pose(10, 10, -20000, 1'b0);
    queue_pose(3000, 3000, 0, 1'b0);
    queue_pose(3500, 3500, 0, 1'b0);
    queue_pose(5, 5, 0, 1'b1);
    queue_pose(5, 5, 0, 1'b0);
    drain();

    // A period of zero, a write to an unused index, and a zero tolerance that
    // still allows arrival exactly on the goal.
    @(posedge clk);
    write_register(REG_FB_PERIOD, 32'd0);
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    write_register(REG_POS_TOL, 32'd0);
    write_register(REG_YAW_TOL, 32'd0);
    cfg_valid <= 1'b0;
    queue_pose(1, 0, 0, 1'b0);
    queue_pose(0, 0, 1, 1'b0);
    queue_pose(0, 0, 0, 1'b0);
    queue_pose(0, 0, 0, 1'b0);
    drain();

    // Random phases: a few registers rewritten, then a short run toward the goal.
    for (int ph = 0; ph < 42; ph++) begin
      @(posedge clk);
      write_register(CFG_IDX_W'(ph % 8), register_value(CFG_IDX_W'(ph % 8)));
      for (int k = $urandom_range(0, 3); k > 0; k--) begin
        idx = CFG_IDX_W'($urandom_range(0, 7));
        write_register(idx, register_value(idx));
      end
      cfg_valid <= 1'b0;
      for (int k = 0; k < 30; k++) queue_random_pose();
      drain();
    end

    errors = errors + command_q.size();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
